[sv/tsai_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp age interval package
// Shared widths, calendar constants, the month length table and the stage
// advance bundle used by the age pipeline and its reference month unit.
// ----------------------------------------------------------------------------
package tsai_pkg;

    localparam int YEAR_W   = 20;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int TOD_W    = 37;
    localparam int MONTHS_W = 24;
    localparam int DAYS_W   = 6;
    localparam int MICROS_W = 38;

    localparam int YD_W  = YEAR_W + 1;
    localparam int MD_W  = MONTH_W + 2;
    localparam int DD_W  = DAY_W + 2;
    localparam int TD_W  = TOD_W + 2;
    localparam int LEN_W = 5;

    localparam logic [TD_W-1:0]  MICROS_IN_DAY  = 39'd86400000000;
    localparam logic [MD_W-1:0]  MONTHS_IN_YEAR = 6'd12;

    localparam int                 RECIP_SHIFT = 25;
    localparam int                 RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP_25    = 21'd1342177;
    localparam int                 PROD_W      = YEAR_W + RECIP_W;
    localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [LEN_W-1:0] LEN_LONG = 5'd31;
    localparam logic [LEN_W-1:0] LEN_LEAP = 5'd29;
    localparam logic [LEN_W-1:0] LEN_MIN  = 5'd28;

    localparam logic [LEN_W-1:0] MONTH_DAYS [12] =
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } adv_t;

    function automatic logic [LEN_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [MONTH_W-1:0] idx;
        logic [LEN_W-1:0]   len;
        idx = month - MONTH_JAN;
        if ((month < MONTH_JAN) || (month > MONTH_DEC))
        begin
            len = LEN_LONG;
        end
        else if ((month == MONTH_FEB) && leap)
        begin
            len = LEN_LEAP;
        end
        else
        begin
            len = MONTH_DAYS[idx];
        end
        return len;
    endfunction

endpackage

[sv/tsai_ref_len.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference month length unit
// Three register stages that find the Gregorian length of the reference
// month, testing the year for divisibility by 25 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module tsai_ref_len (
    input  logic                                    clk,
    input  tsai_pkg::adv_t                          adv,
    input  logic signed [tsai_pkg::YEAR_W-1:0]      year,
    input  logic        [tsai_pkg::MONTH_W-1:0]     month,
    output logic        [tsai_pkg::LEN_W-1:0]       len
);

    logic [tsai_pkg::YEAR_W-1:0]  yabs1_reg;
    logic [tsai_pkg::YEAR_W-1:0]  yabs1_next;
    logic [3:0]                   low1_reg;
    logic [tsai_pkg::MONTH_W-1:0] mon1_reg;

    logic [tsai_pkg::PROD_W-1:0]  prod;
    logic [tsai_pkg::QUOT_W-1:0]  quot2_reg;
    logic [tsai_pkg::YEAR_W-1:0]  yabs2_reg;
    logic [3:0]                   low2_reg;
    logic [tsai_pkg::MONTH_W-1:0] mon2_reg;

    logic [tsai_pkg::YEAR_W-1:0]  quot_ext;
    logic [tsai_pkg::YEAR_W-1:0]  rem_full;
    logic [5:0]                   rem;
    logic                         div25;
    logic                         leap;
    logic [tsai_pkg::LEN_W-1:0]   len_reg;
    logic [tsai_pkg::LEN_W-1:0]   len_next;

    assign yabs1_next = year[tsai_pkg::YEAR_W-1] ? (-year) : year;
    assign prod = tsai_pkg::PROD_W'(yabs1_reg) * tsai_pkg::PROD_W'(tsai_pkg::RECIP_25);

    always_comb
    begin
        quot_ext = tsai_pkg::YEAR_W'(quot2_reg);
        rem_full = yabs2_reg - (quot_ext << 4) - (quot_ext << 3) - quot_ext;
        rem      = rem_full[5:0];
        div25    = (rem == 6'd0) || (rem == 6'd25);
        leap     = (low2_reg[1:0] == 2'b00) && (!div25 || (low2_reg == 4'b0000));
        len_next = tsai_pkg::month_days(mon2_reg, leap);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            yabs1_reg <= yabs1_next;
            low1_reg  <= year[3:0];
            mon1_reg  <= month;
        end
        if (adv.s2)
        begin
            quot2_reg <= prod[tsai_pkg::PROD_W-1:tsai_pkg::RECIP_SHIFT];
            yabs2_reg <= yabs1_reg;
            low2_reg  <= low1_reg;
            mon2_reg  <= mon1_reg;
        end
        if (adv.s3)
        begin
            len_reg <= len_next;
        end
    end

    assign len = len_reg;

endmodule

[sv/timestamp_age_interval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp age interval
// Calendar age of two broken-down timestamps as months, days and microseconds,
// with time, day and month borrows worked in successive pipeline stages.
// ----------------------------------------------------------------------------
// An input transfer moves through the stage valid bits v1_reg to v5_reg in order;
// out_valid is v5_reg, and the result holds while out_stall is high.
// Throughput: one item per cycle; the five-stage pipeline takes a new item
// every cycle unless out_stall holds a full pipeline.
// Reset clears the stage valid bits only; no result is pending after reset.
// ----------------------------------------------------------------------------
module timestamp_age_interval (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [tsai_pkg::YEAR_W-1:0]      year_first,
    input  logic        [tsai_pkg::MONTH_W-1:0]     month_first,
    input  logic        [tsai_pkg::DAY_W-1:0]       day_first,
    input  logic        [tsai_pkg::TOD_W-1:0]       tod_first,
    input  logic signed [tsai_pkg::YEAR_W-1:0]      year_second,
    input  logic        [tsai_pkg::MONTH_W-1:0]     month_second,
    input  logic        [tsai_pkg::DAY_W-1:0]       day_second,
    input  logic        [tsai_pkg::TOD_W-1:0]       tod_second,
    input  logic                                    first_is_earlier,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [tsai_pkg::MONTHS_W-1:0]    age_months,
    output logic signed [tsai_pkg::DAYS_W-1:0]      age_days,
    output logic signed [tsai_pkg::MICROS_W-1:0]    age_micros
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    tsai_pkg::adv_t adv;

    logic signed [tsai_pkg::YD_W-1:0] yd1_reg, yd2_reg, yd3_reg, yd4_reg;
    logic signed [tsai_pkg::MD_W-1:0] md1_reg, md2_reg, md3_reg, md4_reg;
    logic signed [tsai_pkg::DD_W-1:0] dd1_reg, dd2_reg, dd3_reg, dd4_reg;
    logic signed [tsai_pkg::TD_W-1:0] td1_reg, td2_reg, td3_reg, td4_reg;
    logic flip1_reg, flip2_reg, flip3_reg, flip4_reg, flip5_reg;

    logic signed [tsai_pkg::YD_W-1:0] yd1_next;
    logic signed [tsai_pkg::MD_W-1:0] md1_next;
    logic signed [tsai_pkg::DD_W-1:0] dd1_next;
    logic signed [tsai_pkg::TD_W-1:0] td1_next;
    logic signed [tsai_pkg::YD_W-1:0] yd_raw;
    logic signed [tsai_pkg::MD_W-1:0] md_raw;
    logic signed [tsai_pkg::DD_W-1:0] dd_raw;
    logic signed [tsai_pkg::TD_W-1:0] td_raw;

    logic signed [tsai_pkg::YEAR_W-1:0]  ref_year;
    logic        [tsai_pkg::MONTH_W-1:0] ref_month;
    logic        [tsai_pkg::LEN_W-1:0]   ref_len;

    logic signed [tsai_pkg::TD_W-1:0] td_one, td_two, td2_next;
    logic signed [tsai_pkg::DD_W-1:0] dd2_next;
    logic        [1:0]                t_borrow;

    logic signed [tsai_pkg::DD_W-1:0] dd_one, dd_two, dd4_next, len_ext;
    logic signed [tsai_pkg::MD_W-1:0] md4_next;
    logic        [1:0]                d_borrow;

    logic signed [tsai_pkg::MD_W-1:0]     md_one, md_two, md_fin;
    logic        [1:0]                    m_borrow;
    logic        [tsai_pkg::MONTHS_W-1:0] yd_ext, md_ext, yd_fin, months;
    logic        [tsai_pkg::DD_W-1:0]     dd_out;
    logic        [tsai_pkg::TD_W-1:0]     td_out;

    logic [tsai_pkg::MONTHS_W-1:0] months_reg, months_next;
    logic [tsai_pkg::DAYS_W-1:0]   days_reg, days_next;
    logic [tsai_pkg::MICROS_W-1:0] micros_reg, micros_next;

    // A stage moves on when it is empty or the stage after it moves on.
    assign en5 = !v5_reg || !out_stall;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;
    assign adv = '{s1: en1, s2: en2, s3: en3};

    always_comb
    begin
        yd_raw = {year_first[tsai_pkg::YEAR_W-1], year_first}
               - {year_second[tsai_pkg::YEAR_W-1], year_second};
        md_raw = {2'b00, month_first} - {2'b00, month_second};
        dd_raw = {2'b00, day_first} - {2'b00, day_second};
        td_raw = {2'b00, tod_first} - {2'b00, tod_second};
        yd1_next  = first_is_earlier ? -yd_raw : yd_raw;
        md1_next  = first_is_earlier ? -md_raw : md_raw;
        dd1_next  = first_is_earlier ? -dd_raw : dd_raw;
        td1_next  = first_is_earlier ? -td_raw : td_raw;
        ref_year  = first_is_earlier ? year_first : year_second;
        ref_month = first_is_earlier ? month_first : month_second;
    end

    tsai_ref_len u_ref_len (
        .clk   (clk),
        .adv   (adv),
        .year  (ref_year),
        .month (ref_month),
        .len   (ref_len)
    );

    always_comb
    begin
        td_one = td1_reg + signed'(tsai_pkg::MICROS_IN_DAY);
        td_two = td_one + signed'(tsai_pkg::MICROS_IN_DAY);
        priority if (td1_reg >= 0)
        begin
            td2_next = td1_reg;
            t_borrow = 2'd0;
        end
        else if (td_one >= 0)
        begin
            td2_next = td_one;
            t_borrow = 2'd1;
        end
        else
        begin
            td2_next = td_two;
            t_borrow = 2'd2;
        end
        dd2_next = dd1_reg - signed'({5'd0, t_borrow});
    end

    always_comb
    begin
        len_ext = signed'({2'b00, ref_len});
        dd_one  = dd3_reg + len_ext;
        dd_two  = dd_one + len_ext;
        priority if (dd3_reg >= 0)
        begin
            dd4_next = dd3_reg;
            d_borrow = 2'd0;
        end
        else if (dd_one >= 0)
        begin
            dd4_next = dd_one;
            d_borrow = 2'd1;
        end
        else
        begin
            dd4_next = dd_two;
            d_borrow = 2'd2;
        end
        md4_next = md3_reg - signed'({4'd0, d_borrow});
    end

    always_comb
    begin
        md_one = md4_reg + signed'(tsai_pkg::MONTHS_IN_YEAR);
        md_two = md_one + signed'(tsai_pkg::MONTHS_IN_YEAR);
        priority if (md4_reg >= 0)
        begin
            md_fin   = md4_reg;
            m_borrow = 2'd0;
        end
        else if (md_one >= 0)
        begin
            md_fin   = md_one;
            m_borrow = 2'd1;
        end
        else
        begin
            md_fin   = md_two;
            m_borrow = 2'd2;
        end
        yd_ext = {{(tsai_pkg::MONTHS_W-tsai_pkg::YD_W){yd4_reg[tsai_pkg::YD_W-1]}}, yd4_reg};
        md_ext = {{(tsai_pkg::MONTHS_W-tsai_pkg::MD_W){md_fin[tsai_pkg::MD_W-1]}}, md_fin};
        yd_fin = yd_ext - {22'd0, m_borrow};
        months = (yd_fin << 3) + (yd_fin << 2) + md_ext;
        months_next = flip4_reg ? -months : months;
        dd_out      = flip4_reg ? -dd4_reg : dd4_reg;
        td_out      = flip4_reg ? -td4_reg : td4_reg;
        days_next   = dd_out[tsai_pkg::DAYS_W-1:0];
        micros_next = td_out[tsai_pkg::MICROS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            yd1_reg   <= yd1_next;
            md1_reg   <= md1_next;
            dd1_reg   <= dd1_next;
            td1_reg   <= td1_next;
            flip1_reg <= first_is_earlier;
        end
        if (en2)
        begin
            yd2_reg   <= yd1_reg;
            md2_reg   <= md1_reg;
            dd2_reg   <= dd2_next;
            td2_reg   <= td2_next;
            flip2_reg <= flip1_reg;
        end
        if (en3)
        begin
            yd3_reg   <= yd2_reg;
            md3_reg   <= md2_reg;
            dd3_reg   <= dd2_reg;
            td3_reg   <= td2_reg;
            flip3_reg <= flip2_reg;
        end
        if (en4)
        begin
            yd4_reg   <= yd3_reg;
            md4_reg   <= md4_next;
            dd4_reg   <= dd4_next;
            td4_reg   <= td3_reg;
            flip4_reg <= flip3_reg;
        end
        if (en5)
        begin
            months_reg <= months_next;
            days_reg   <= days_next;
            micros_reg <= micros_next;
            flip5_reg  <= flip4_reg;
        end
    end

    assign out_valid  = v5_reg;
    assign age_months = signed'(months_reg);
    assign age_days   = signed'(days_reg);
    assign age_micros = signed'(micros_reg);

    // The input side may only stall when every stage holds an item.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg))
        else $error("input stalled with an empty pipeline stage");

    // The reference month length must be a real month length when it is used.
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (ref_len >= tsai_pkg::LEN_MIN))
        else $error("reference month length below 28 days");

    // Without the sign flip, every borrow leaves non-negative days and time.
    a_forward_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !flip5_reg) |-> (!age_days[tsai_pkg::DAYS_W-1]
            && !age_micros[tsai_pkg::MICROS_W-1]))
        else $error("negative day or time part without sign flip");

    // The day part never reaches the most negative code of its width.
    a_days_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (age_days != 6'b100000))
        else $error("day part out of range");

endmodule
